// ----- src/hrm_pkg.sv -----
// ----------------------------------------------------------------------------
// Hole mask engine package
// Shared constants, command codes and transaction types of the hole mask engine.
// ----------------------------------------------------------------------------
package hrm_pkg;

    localparam int MASK_WIDTH  = 1024;
    localparam int MASK_HEIGHT = 512;

    localparam int XW        = (MASK_WIDTH > 1) ? $clog2(MASK_WIDTH) : 1;
    localparam int YW        = (MASK_HEIGHT > 1) ? $clog2(MASK_HEIGHT) : 1;
    localparam int WORD_W    = 32;
    localparam int WPR       = (MASK_WIDTH + WORD_W - 1) / WORD_W;
    localparam int RAM_DEPTH = MASK_HEIGHT * WPR;
    localparam int AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    localparam logic [7:0]  THRESH_RESET = 8'd128;
    localparam logic [19:0] COUNT_MAX    = 20'hFFFFF;

    localparam logic [2:0] CMD_LOAD    = 3'd0;
    localparam logic [2:0] CMD_CIRCLE  = 3'd1;
    localparam logic [2:0] CMD_RECT    = 3'd2;
    localparam logic [2:0] CMD_QUERY   = 3'd3;
    localparam logic [2:0] CMD_HIT     = 3'd4;
    localparam logic [2:0] CMD_COMPOSE = 3'd5;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [9:0]         radius;
        logic [10:0]        extent_w;
        logic [10:0]        extent_h;
        logic [31:0]        fg_pixel;
        logic [31:0]        bg_pixel;
    } t_req;

    typedef struct packed {
        logic [19:0] holes_punched;
        logic        is_solid;
        logic        hit_found;
        logic [9:0]  hit_x;
        logic [8:0]  hit_y;
        logic [31:0] pixel_out;
    } t_rsp;

    typedef struct packed {
        logic setup;
        logic rd;
        logic proc;
        logic clr;
    } t_ctl;

    typedef struct packed {
        logic empty;
        logic last;
        logic stop;
        logic clr_last;
    } t_sts;

endpackage

// ----- src/raster_hole_mask_engine.sv -----
// ----------------------------------------------------------------------------
// Raster hole mask engine
// One-bit hole map over a pixel raster with load, shape destroy, query,
// collision search and compose commands.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start, busy          i_req (t_req)
//  result    o_done strobe        o_rsp (t_rsp)
//  config    i_cfg_we             i_cfg_wdata (alpha threshold)
//
// A command sets up, checks its clipped area, then reads each pixel's 32-bit
// map word through a single RAM; load, circle and rect also write it back.
// A collision search ends at the first solid pixel; an empty area skips the walk.
// After reset a clearing pass of one map word per cycle over all 16384 words
// runs with busy high. The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module raster_hole_mask_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  hrm_pkg::t_req i_req,
    output logic          o_done,
    output hrm_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);
    import hrm_pkg::*;

    t_ctl ctl;
    t_sts sts;

    hrm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    hrm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (sts),
        .o_rsp       (o_rsp)
    );
endmodule

// ----- src/hrm_ram.sv -----
// ----------------------------------------------------------------------------
// Hole mask RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/hrm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Hole mask controller
// Sequences the clearing pass, command setup and the per-pixel read and update.
// ----------------------------------------------------------------------------
module hrm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  hrm_pkg::t_sts i_sts,
    output hrm_pkg::t_ctl o_ctl,
    output logic          o_busy,
    output logic          o_done
);
    import hrm_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_PROC = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_CLR: begin
                o_ctl.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.setup = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_sts.empty ? S_DONE : S_RD;
            end
            S_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = S_PROC;
            end
            S_PROC: begin
                o_ctl.proc = 1'b1;
                n_state    = (i_sts.last || i_sts.stop) ? S_DONE : S_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
endmodule

// ----- src/hrm_dp.sv -----
// ----------------------------------------------------------------------------
// Hole mask datapath
// Clipping, pixel walk, circle test, map word update and result registers.
// ----------------------------------------------------------------------------
module hrm_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hrm_pkg::t_ctl i_ctl,
    input  hrm_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    output hrm_pkg::t_sts o_sts,
    output hrm_pkg::t_rsp o_rsp
);
    import hrm_pkg::*;

    localparam logic signed [13:0] XMAX = 14'(MASK_WIDTH - 1);
    localparam logic signed [13:0] YMAX = 14'(MASK_HEIGHT - 1);

    logic [7:0]         r_thr;
    logic [AW-1:0]      r_clr_addr;
    logic [2:0]         r_cmd;
    logic signed [13:0] r_px;
    logic signed [13:0] r_py;
    logic [19:0]        r_rad2;
    logic [31:0]        r_fg;
    logic [31:0]        r_bg;
    logic [XW-1:0]      r_x0;
    logic [XW-1:0]      r_x1;
    logic [YW-1:0]      r_y1;
    logic [XW-1:0]      r_x;
    logic [YW-1:0]      r_y;
    logic               r_empty;
    logic               r_inside;
    t_rsp               r_rsp;

    logic signed [13:0] px_e;
    logic signed [13:0] py_e;
    logic signed [13:0] lox;
    logic signed [13:0] hix;
    logic signed [13:0] loy;
    logic signed [13:0] hiy;
    logic signed [13:0] x0s;
    logic signed [13:0] x1s;
    logic signed [13:0] y0s;
    logic signed [13:0] y1s;
    logic               valid_cmd;

    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic signed [27:0] dx2;
    logic signed [27:0] dy2;
    logic [28:0]        dsum;

    logic [15:0]        xe;
    logic [AW-1:0]      pix_addr;
    logic [4:0]         bsel;
    logic [WORD_W-1:0]  rdata;
    logic [WORD_W-1:0]  wdata;
    logic [AW-1:0]      waddr;
    logic               we;
    logic               bit_cur;
    logic               bit_new;

    always_comb begin
        px_e      = 14'(i_req.pos_x);
        py_e      = 14'(i_req.pos_y);
        valid_cmd = 1'b1;
        lox       = px_e;
        hix       = px_e;
        loy       = py_e;
        hiy       = py_e;
        unique case (i_req.req_type) inside
            CMD_CIRCLE: begin
                lox = px_e - $signed({4'b0, i_req.radius});
                hix = px_e + $signed({4'b0, i_req.radius});
                loy = py_e - $signed({4'b0, i_req.radius});
                hiy = py_e + $signed({4'b0, i_req.radius});
            end
            CMD_RECT, CMD_HIT: begin
                hix = px_e + $signed({3'b0, i_req.extent_w});
                hiy = py_e + $signed({3'b0, i_req.extent_h});
            end
            CMD_LOAD, CMD_QUERY, CMD_COMPOSE: begin
                valid_cmd = 1'b1;
            end
            default: begin
                valid_cmd = 1'b0;
            end
        endcase
        x0s = (lox < 14'sd0) ? 14'sd0 : lox;
        x1s = (hix > XMAX) ? XMAX : hix;
        y0s = (loy < 14'sd0) ? 14'sd0 : loy;
        y1s = (hiy > YMAX) ? YMAX : hiy;
    end

    always_comb begin
        dx   = $signed(14'(r_x)) - r_px;
        dy   = $signed(14'(r_y)) - r_py;
        dx2  = dx * dx;
        dy2  = dy * dy;
        dsum = {1'b0, 28'(dx2)} + {1'b0, 28'(dy2)};
    end

    always_comb begin
        xe       = 16'(r_x);
        bsel     = xe[4:0];
        pix_addr = AW'(32'(r_y) * 32'(WPR) + 32'(xe[15:5]));
        bit_cur  = rdata[bsel];
        unique case (r_cmd)
            CMD_LOAD:   bit_new = (r_fg[7:0] < r_thr);
            CMD_CIRCLE: bit_new = bit_cur | r_inside;
            CMD_RECT:   bit_new = 1'b1;
            default:    bit_new = bit_cur;
        endcase
        wdata       = rdata;
        wdata[bsel] = bit_new;
        if (i_ctl.clr) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else begin
            we    = i_ctl.proc &&
                    (r_cmd == CMD_LOAD || r_cmd == CMD_CIRCLE || r_cmd == CMD_RECT);
            waddr = pix_addr;
        end
    end

    hrm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (pix_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THRESH_RESET;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_ctl.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.setup) begin
            r_cmd   <= i_req.req_type;
            r_px    <= px_e;
            r_py    <= py_e;
            r_rad2  <= 20'(i_req.radius * i_req.radius);
            r_fg    <= i_req.fg_pixel;
            r_bg    <= i_req.bg_pixel;
            r_x0    <= XW'(x0s);
            r_x1    <= XW'(x1s);
            r_y1    <= YW'(y1s);
            r_x     <= XW'(x0s);
            r_y     <= YW'(y0s);
            r_empty <= !valid_cmd || (x0s > x1s) || (y0s > y1s);
            r_rsp   <= '0;
            if (i_req.req_type == CMD_COMPOSE) begin
                r_rsp.pixel_out <= i_req.bg_pixel;
            end
        end
        if (i_ctl.rd) begin
            r_inside <= (dsum <= 29'(r_rad2));
        end
        if (i_ctl.proc) begin
            if (r_x == r_x1) begin
                r_x <= r_x0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
            case (r_cmd) inside
                CMD_CIRCLE, CMD_RECT: begin
                    if (bit_new && !bit_cur && r_rsp.holes_punched != COUNT_MAX) begin
                        r_rsp.holes_punched <= r_rsp.holes_punched + 1'b1;
                    end
                end
                CMD_QUERY: begin
                    r_rsp.is_solid <= !bit_cur;
                end
                CMD_HIT: begin
                    if (!bit_cur) begin
                        r_rsp.hit_found <= 1'b1;
                        r_rsp.hit_x     <= 10'(r_x);
                        r_rsp.hit_y     <= 9'(r_y);
                    end
                end
                CMD_COMPOSE: begin
                    r_rsp.pixel_out <= bit_cur ? r_bg : r_fg;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_sts.empty    = r_empty;
        o_sts.last     = (r_x == r_x1) && (r_y == r_y1);
        o_sts.stop     = (r_cmd == CMD_HIT) && !bit_cur;
        o_sts.clr_last = (r_clr_addr == AW'(RAM_DEPTH - 1));
    end

    assign o_rsp = r_rsp;
endmodule
